// ===== hw/rtl/smt_pkg.sv =====
package smt_pkg;

  localparam int SMT_CAPACITY = 64;
  localparam int VALUE_W      = 32;
  localparam int ACTION_W     = 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_SPARE  = 2'd3
  } smt_action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_SPARE     = 2'd3
  } smt_status_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic cmp;  // latch compare flags against the key
    logic ins;  // shift up from the insert point, drop key in
    logic rem;  // shift down onto the matching entry
  } smt_ctrl_t;

endpackage

// ===== hw/rtl/smt_if.sv =====
interface smt_in_if;
  import smt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface smt_out_if #(
  parameter int CNT_W = 7
);
  import smt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic                       found;
  logic signed [VALUE_W-1:0]  value_out;
  logic [CNT_W-1:0]           entry_count_out;

  modport source (output valid, output status, output found, output value_out,
                  output entry_count_out, input ready);
  modport sink   (input valid, input status, input found, input value_out,
                  input entry_count_out, output ready);
endinterface

// ===== hw/rtl/smt_cell.sv =====
module smt_cell import smt_pkg::*; (
  input  logic                      clk,
  input  smt_ctrl_t                 ctrl,
  input  logic                      cell_valid,
  input  logic signed [VALUE_W-1:0] key,
  input  logic signed [VALUE_W-1:0] prev_entry,
  input  logic signed [VALUE_W-1:0] next_entry,
  input  logic                      prev_lt,
  output logic signed [VALUE_W-1:0] entry,
  output logic                      lt,
  output logic                      eq
);

  logic signed [VALUE_W-1:0] entry_r;
  logic                      lt_r;
  logic                      eq_r;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt_r <= cell_valid && (entry_r < key);
      eq_r <= cell_valid && (entry_r == key);
    end
    // Cells below the insert/remove point hold their entry.
    if (ctrl.ins && !lt_r) begin
      entry_r <= prev_lt ? key : prev_entry;
    end else if (ctrl.rem && !lt_r) begin
      entry_r <= next_entry;
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

// ===== hw/rtl/sorted_multiset_table.sv =====
// The result is registered at the commit in ST_CMP, which follows the compare at
// the accepting edge. The row of cells compares at accept and shifts at commit,
// and the next item waits for that shift.
// A held result stalls the commit, and no new item is taken until it commits.
// Reset (rst_n low, synchronous) clears the entry count, the control state and
// the result valid; cell contents are not cleared and are read only once written.
module sorted_multiset_table import smt_pkg::*; #(
  parameter int CAPACITY = SMT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  smt_in_if.sink          in_ch,
  smt_out_if.source       out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CMP  = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [VALUE_W-1:0] key_r;
  logic [ACTION_W-1:0]       act_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       status_r;
  logic                      found_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]          count_r;

  logic signed [VALUE_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]       lt_vec;
  logic [CAPACITY-1:0]       eq_vec;

  logic                      accept;
  logic                      commit;
  logic                      full;
  logic                      found;
  logic                      do_ins;
  logic                      do_rem;
  logic signed [VALUE_W-1:0] cell_key;
  smt_ctrl_t                 ctrl;
  logic [STATUS_W-1:0]       status_nxt;

  // One item in flight: take a new transfer only while the row is idle.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Commit once the result register is free or being drained this cycle.
  assign commit = (state_r == ST_CMP) && (!out_valid_r || out_ch.ready);
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  // The table is sorted, so any valid equal entry sits at the lower bound.
  assign found  = |eq_vec;
  assign do_ins = commit && (act_r == ACT_INSERT) && !full;
  assign do_rem = commit && (act_r == ACT_REMOVE) && found;

  // Compare against the incoming value at accept, then hold the latched key.
  assign cell_key = (state_r == ST_IDLE) ? in_ch.value : key_r;

  always_comb begin
    ctrl     = '0;
    ctrl.cmp = accept;
    ctrl.ins = do_ins;
    ctrl.rem = do_rem;
  end

  // Row of compare-and-shift cells; each trades entries with its neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_entry;
    logic signed [VALUE_W-1:0] next_entry;
    logic                      prev_lt;

    if (i == 0) begin : g_first
      assign prev_entry = cell_key;
      assign prev_lt    = 1'b1;
    end else begin : g_mid
      assign prev_entry = entry[i-1];
      assign prev_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_body
      assign next_entry = entry[i+1];
    end

    smt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_valid (CNT_W'(i) < cnt_r),
      .key        (cell_key),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .prev_lt    (prev_lt),
      .entry      (entry[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rem) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    case (act_r)
      ACT_INSERT: status_nxt = full ? STAT_FULL : STAT_DONE;
      default:    status_nxt = found ? STAT_DONE : STAT_NOT_FOUND;
    endcase
  end

  // Drop the result on a drain, load a fresh one on commit.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_ch.value;
      act_r <= in_ch.action;
    end
    if (commit) begin
      status_r <= status_nxt;
      found_r  <= found;
      value_r  <= key_r;
      count_r  <= cnt_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.found           = found_r;
  assign out_ch.value_out       = value_r;
  assign out_ch.entry_count_out = count_r;

endmodule

// ===== hw/rtl/smt_checker.sv =====
module smt_checker import smt_pkg::*; #(
  parameter int CAPACITY = SMT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_found,
  input logic [CNT_W-1:0]    out_count
);

  // Hold a pending result until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // One item at a time: no transfer right after a transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> out_count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_NOT_FOUND) |-> !out_found)
    else $error("not-found status with found flag set");

endmodule

bind sorted_multiset_table smt_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_smt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_found  (out_ch.found),
  .out_count  (out_ch.entry_count_out)
);
